[rtl/core/cubic_bezier_arc_length_eval_unit_assert.svh]
// Assertion macros used by the top module of the Bezier arc-length unit.
`ifndef CUBIC_BEZIER_ARC_LENGTH_EVAL_UNIT_ASSERT_SVH
`define CUBIC_BEZIER_ARC_LENGTH_EVAL_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BCAL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define BCAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BCAL_ASSERT(lbl, clk, rstn, prop)
`define BCAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/core/bcal_pkg.sv]
`default_nettype none
package bcal_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned TW     = 17;
  localparam int unsigned LenW   = 40;
  localparam int unsigned ChordW = 33;
  localparam int unsigned RatioW = 16;

  localparam logic [TW-1:0]   TOne   = 17'h10000;
  localparam logic [LenW-1:0] LenMax = '1;

  localparam logic [2:0] REG_START_X  = 3'd0;
  localparam logic [2:0] REG_START_Y  = 3'd1;
  localparam logic [2:0] REG_GUIDE1_X = 3'd2;
  localparam logic [2:0] REG_GUIDE1_Y = 3'd3;
  localparam logic [2:0] REG_GUIDE2_X = 3'd4;
  localparam logic [2:0] REG_GUIDE2_Y = 3'd5;
  localparam logic [2:0] REG_END_X    = 3'd6;
  localparam logic [2:0] REG_END_Y    = 3'd7;

  localparam logic [2:0] LastStep = 3'd5;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    coord_t          a;
    coord_t          b;
    logic [TW-1:0]   t;
  } lerp_req_t;

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } chord_pts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EV_ISSUE,
    ST_EV_WAIT,
    ST_CH_START,
    ST_CH_WAIT,
    ST_DECIDE,
    ST_DIV_WAIT,
    ST_FX_ISSUE,
    ST_FX_WAIT,
    ST_FY_ISSUE,
    ST_FY_WAIT,
    ST_OUT
  } seq_state_e;

  typedef enum logic [1:0] {
    DST_PREV,
    DST_NEXT,
    DST_RES
  } eval_dst_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SQX,
    CS_SQY,
    CS_ROOT,
    CS_DONE
  } chord_state_e;
endpackage
`default_nettype wire

[rtl/core/cubic_bezier_arc_length_eval_unit.sv]
// Each request walks SUBDIVISIONS chords; each chord takes point evaluation on the shared lerp
// unit, a launch state and the chord unit (two squares, 32 root steps and a done state).
// A new request is accepted only from idle, after the result; busy stays high through the result.
// The result is shown for one cycle with done_o; the receiver cannot stall it.
// Reset (async, active low) clears the control points to zero and idles the sequencer.
`default_nettype none
`include "cubic_bezier_arc_length_eval_unit_assert.svh"
module cubic_bezier_arc_length_eval_unit import bcal_pkg::*; #(
  parameter int unsigned SUBDIVISIONS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_wdata_i,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [TW-1:0]      param_t_i,
  input  logic [LenW-1:0]    distance_i,
  output logic               done_o,
  output logic signed [CoordW-1:0] point_x_o,
  output logic signed [CoordW-1:0] point_y_o,
  output logic [LenW-1:0]    total_length_o
);
  localparam int unsigned IW    = $clog2(SUBDIVISIONS + 1);
  localparam int unsigned RW    = $clog2(SUBDIVISIONS) + 1;
  localparam int unsigned TotW  = ChordW + IW + 1;
  localparam int unsigned TStep = 65536 / SUBDIVISIONS;
  localparam int unsigned TRem  = 65536 % SUBDIVISIONS;

  seq_state_e state_q, state_d;
  eval_dst_e  dst_q;

  coord_t cfg_q [8];
  coord_t w_q   [5];
  coord_t prevx_q, prevy_q, nextx_q, nexty_q, resx_q, resy_q;
  coord_t mx0_q, my0_q, mx1_q, my1_q;

  logic              op_q, c_q, found_q;
  logic [2:0]        s_q;
  logic [TW-1:0]     pt_q, tacc_q, tacc_n;
  logic [RW-1:0]     trem_q, trem_n;
  logic [RW:0]       rsum;
  logic              tcarry;
  logic [IW-1:0]     idx_q;
  logic [LenW-1:0]   dist_q, cur_q;
  logic [LenW:0]     newcur;
  logic [TotW-1:0]   total_q;
  logic [ChordW-1:0] f_q, mlen_q, len;
  logic [RatioW-1:0] ratio_q, quo;
  logic              dist_end, dist_zero, accept;
  logic              chord_start, chord_done, div_start, div_done;

  lerp_req_t  lreq;
  coord_t     lres;
  coord_t     p0, p1, p2, p3;
  chord_pts_t cpts;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Parameter of the next chord point: floor(i * 65536 / SUBDIVISIONS), stepped.
  assign rsum   = {1'b0, trem_q} + (RW+1)'(TRem);
  assign tcarry = rsum >= (RW+1)'(SUBDIVISIONS);
  assign trem_n = tcarry ? RW'(rsum - (RW+1)'(SUBDIVISIONS)) : rsum[RW-1:0];
  assign tacc_n = tacc_q + TW'(TStep) + TW'(tcarry);

  assign newcur    = {1'b0, cur_q} + (LenW+1)'(len);
  assign dist_end  = 64'(dist_q) >= 64'(total_q);
  assign dist_zero = (dist_q == '0);

  assign p0 = c_q ? cfg_q[REG_START_Y]  : cfg_q[REG_START_X];
  assign p1 = c_q ? cfg_q[REG_GUIDE1_Y] : cfg_q[REG_GUIDE1_X];
  assign p2 = c_q ? cfg_q[REG_GUIDE2_Y] : cfg_q[REG_GUIDE2_X];
  assign p3 = c_q ? cfg_q[REG_END_Y]    : cfg_q[REG_END_X];

  always_comb begin
    lreq.a = p0;
    lreq.b = p1;
    lreq.t = (dst_q == DST_RES) ? pt_q : tacc_q;
    case (state_q)
      ST_EV_ISSUE: begin
        case (s_q)
          3'd0: begin lreq.a = p0;     lreq.b = p1;     end
          3'd1: begin lreq.a = p1;     lreq.b = p2;     end
          3'd2: begin lreq.a = p2;     lreq.b = p3;     end
          3'd3: begin lreq.a = w_q[0]; lreq.b = w_q[1]; end
          3'd4: begin lreq.a = w_q[1]; lreq.b = w_q[2]; end
          default: begin lreq.a = w_q[3]; lreq.b = w_q[4]; end
        endcase
      end
      ST_FX_ISSUE: begin
        lreq.a = mx0_q;
        lreq.b = mx1_q;
        lreq.t = {1'b0, ratio_q};
      end
      ST_FY_ISSUE: begin
        lreq.a = my0_q;
        lreq.b = my1_q;
        lreq.t = {1'b0, ratio_q};
      end
      default: ;
    endcase
  end

  bcal_lerp u_lerp (
    .clk_i (clk_i),
    .req_i (lreq),
    .res_o (lres)
  );

  assign cpts = '{x0: prevx_q, y0: prevy_q, x1: nextx_q, y1: nexty_q};

  bcal_chord u_chord (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (chord_start),
    .pts_i   (cpts),
    .done_o  (chord_done),
    .len_o   (len)
  );

  bcal_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (f_q),
    .den_i   (mlen_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int k = 0; k < 8; k++) cfg_q[k] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cfg_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    chord_start = 1'b0;
    div_start   = 1'b0;
    done_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_EV_ISSUE;
      end
      ST_EV_ISSUE: state_d = ST_EV_WAIT;
      ST_EV_WAIT: begin
        state_d = ST_EV_ISSUE;
        if (s_q == LastStep && c_q) begin
          case (dst_q)
            DST_NEXT: state_d = ST_CH_START;
            DST_RES:  state_d = ST_OUT;
            default:  state_d = ST_EV_ISSUE;
          endcase
        end
      end
      ST_CH_START: begin
        chord_start = 1'b1;
        state_d     = ST_CH_WAIT;
      end
      ST_CH_WAIT: begin
        if (chord_done) begin
          state_d = (idx_q == IW'(SUBDIVISIONS - 1)) ? ST_DECIDE : ST_EV_ISSUE;
        end
      end
      ST_DECIDE: begin
        if (!op_q) begin
          state_d = ST_EV_ISSUE;
        end else if (dist_end || dist_zero) begin
          state_d = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) state_d = ST_FX_ISSUE;
      end
      ST_FX_ISSUE: state_d = ST_FX_WAIT;
      ST_FX_WAIT:  state_d = ST_FY_ISSUE;
      ST_FY_ISSUE: state_d = ST_FY_WAIT;
      ST_FY_WAIT:  state_d = ST_OUT;
      ST_OUT: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_q    <= op_i;
          pt_q    <= (param_t_i > TOne) ? TOne : param_t_i;
          dist_q  <= distance_i;
          tacc_q  <= '0;
          trem_q  <= '0;
          idx_q   <= '0;
          cur_q   <= '0;
          total_q <= '0;
          found_q <= 1'b0;
          dst_q   <= DST_PREV;
          s_q     <= '0;
          c_q     <= 1'b0;
        end
      end
      ST_EV_WAIT: begin
        if (s_q != LastStep) begin
          w_q[s_q] <= lres;
          s_q      <= s_q + 3'd1;
        end else begin
          s_q <= '0;
          c_q <= !c_q;
          case (dst_q)
            DST_PREV: begin
              if (c_q) prevy_q <= lres; else prevx_q <= lres;
            end
            DST_NEXT: begin
              if (c_q) nexty_q <= lres; else nextx_q <= lres;
            end
            default: begin
              if (c_q) resy_q <= lres; else resx_q <= lres;
            end
          endcase
          if (c_q && dst_q == DST_PREV) begin
            tacc_q <= tacc_n;
            trem_q <= trem_n;
            dst_q  <= DST_NEXT;
          end
        end
      end
      ST_CH_WAIT: begin
        if (chord_done) begin
          total_q <= total_q + TotW'(len);
          if (!found_q) begin
            // First chord whose end passes the requested distance.
            if (newcur > {1'b0, dist_q}) begin
              found_q <= 1'b1;
              f_q     <= ChordW'(dist_q - cur_q);
              mlen_q  <= len;
              mx0_q   <= prevx_q;
              my0_q   <= prevy_q;
              mx1_q   <= nextx_q;
              my1_q   <= nexty_q;
            end else begin
              cur_q <= newcur[LenW-1:0];
            end
          end
          prevx_q <= nextx_q;
          prevy_q <= nexty_q;
          if (idx_q != IW'(SUBDIVISIONS - 1)) begin
            idx_q  <= idx_q + IW'(1);
            tacc_q <= tacc_n;
            trem_q <= trem_n;
          end
        end
      end
      ST_DECIDE: begin
        if (!op_q) begin
          dst_q <= DST_RES;
          s_q   <= '0;
          c_q   <= 1'b0;
        end else if (dist_end) begin
          resx_q <= cfg_q[REG_END_X];
          resy_q <= cfg_q[REG_END_Y];
        end else if (dist_zero) begin
          resx_q <= cfg_q[REG_START_X];
          resy_q <= cfg_q[REG_START_Y];
        end else if (!found_q) begin
          resx_q <= cfg_q[REG_END_X];
          resy_q <= cfg_q[REG_END_Y];
        end
      end
      ST_DIV_WAIT: begin
        if (div_done) ratio_q <= (mlen_q == '0) ? '0 : quo;
      end
      ST_FX_WAIT: resx_q <= found_q ? lres : cfg_q[REG_END_X];
      ST_FY_WAIT: resy_q <= found_q ? lres : cfg_q[REG_END_Y];
      default: ;
    endcase
  end

  // Lerp results stay between their end points, so the points never leave range.
  assign point_x_o      = resx_q;
  assign point_y_o      = resy_q;
  assign total_length_o = (64'(total_q) > 64'(LenMax)) ? LenMax : LenW'(total_q);

  `BCAL_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy)
  `BCAL_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `BCAL_ASSERT(a_offset_in_chord, clk_i, rst_ni, (busy && found_q) |-> (f_q < mlen_q))
  `BCAL_ASSERT(a_idx_range, clk_i, rst_ni, busy |-> (idx_q < IW'(SUBDIVISIONS)))
endmodule
`default_nettype wire

[rtl/core/bcal_lerp.sv]
`default_nettype none
module bcal_lerp import bcal_pkg::*; (
  input  logic      clk_i,
  input  lerp_req_t req_i,
  output coord_t    res_o
);
  logic signed [CoordW:0]       diff;
  logic signed [TW:0]           ts;
  logic signed [CoordW+TW+1:0]  prod_d;
  logic signed [CoordW+TW+1:0]  prod_q;
  logic signed [CoordW+TW+1:0]  rnd;
  coord_t                       a_q;

  assign diff   = {req_i.b[CoordW-1], req_i.b} - {req_i.a[CoordW-1], req_i.a};
  assign ts     = {1'b0, req_i.t};
  assign prod_d = diff * ts;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    a_q    <= req_i.a;
  end

  // Round half up by adding one half and flooring; the result always lies between a and b.
  assign rnd   = (prod_q + (CoordW+TW+2)'(32768)) >>> 16;
  assign res_o = a_q + rnd[CoordW-1:0];
endmodule
`default_nettype wire

[rtl/core/bcal_chord.sv]
`default_nettype none
module bcal_chord import bcal_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  chord_pts_t        pts_i,
  output logic              done_o,
  output logic [ChordW-1:0] len_o
);
  chord_state_e state_q, state_d;

  logic signed [CoordW:0] sdx, sdy;
  logic [CoordW:0]        dx, dy;
  logic                   half;
  logic [30:0]            dxs_q, dys_q, mop;
  logic [61:0]            sq;
  logic                   half_q;
  logic [62:0]            n_q, bit_q, res_q;
  logic [63:0]            trial;

  assign sdx  = {pts_i.x1[CoordW-1], pts_i.x1} - {pts_i.x0[CoordW-1], pts_i.x0};
  assign sdy  = {pts_i.y1[CoordW-1], pts_i.y1} - {pts_i.y0[CoordW-1], pts_i.y0};
  assign dx   = sdx[CoordW] ? (CoordW+1)'(-sdx) : (CoordW+1)'(sdx);
  assign dy   = sdy[CoordW] ? (CoordW+1)'(-sdy) : (CoordW+1)'(sdy);
  assign half = (dx[CoordW:31] != '0) || (dy[CoordW:31] != '0);

  assign mop   = (state_q == CS_SQX) ? dxs_q : dys_q;
  assign sq    = mop * mop;
  assign trial = {1'b0, res_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_o  = 1'b0;
    case (state_q)
      CS_IDLE: begin
        if (start_i) state_d = CS_SQX;
      end
      CS_SQX:  state_d = CS_SQY;
      CS_SQY:  state_d = CS_ROOT;
      CS_ROOT: begin
        if (bit_q[0]) state_d = CS_DONE;
      end
      CS_DONE: begin
        done_o  = 1'b1;
        state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  // Halve large deltas, sum their squares, then a bit-by-bit integer square root, one result bit per cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          half_q <= half;
          dxs_q  <= half ? dx[31:1] : dx[30:0];
          dys_q  <= half ? dy[31:1] : dy[30:0];
        end
      end
      CS_SQX: n_q <= 63'(sq);
      CS_SQY: begin
        n_q   <= n_q + 63'(sq);
        res_q <= '0;
        bit_q <= 63'(1) << 62;
      end
      CS_ROOT: begin
        if ({1'b0, n_q} >= trial) begin
          n_q   <= n_q - trial[62:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      default: ;
    endcase
  end

  assign len_o = half_q ? {res_q[31:0], 1'b0} : {1'b0, res_q[31:0]};
endmodule
`default_nettype wire

[rtl/core/bcal_div.sv]
`default_nettype none
module bcal_div import bcal_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [ChordW-1:0] num_i,
  input  logic [ChordW-1:0] den_i,
  output logic              done_o,
  output logic [RatioW-1:0] quo_o
);
  logic              run_q, done_q;
  logic [3:0]        cnt_q;
  logic [ChordW-1:0] rem_q, den_q;
  logic [ChordW:0]   remsh;
  logic              ge;

  assign remsh = {rem_q, 1'b0};
  assign ge    = remsh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Restoring division; the numerator is below the divisor, so the
  // quotient of num * 2^16 fits in sixteen bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_o <= '0;
    end else if (run_q) begin
      rem_q <= ge ? ChordW'(remsh - {1'b0, den_q}) : remsh[ChordW-1:0];
      quo_o <= {quo_o[RatioW-2:0], ge};
    end
  end

  assign done_o = done_q;
endmodule
`default_nettype wire
